>>> hdl/tgarle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_pkg
// shared types, register indexes and defaults for the tga rle pixel decoder
// ----------------------------------------------------------------------------
package tgarle_pkg;

  localparam int MaxPixelBytesDefault = 4;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    RegBytesPerPixel = 3'd0,
    RegImageWidth    = 3'd1,
    RegImageHeight   = 3'd2,
    RegRleMode       = 3'd3,
    RegSwapRedBlue   = 3'd4,
    RegClampIndex    = 3'd5,
    RegMapLength     = 3'd6
  } cfg_reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // packet header fields
  localparam int HdrRunBit = 7;
  localparam logic [6:0] HdrCountMask = 7'd127;

  typedef struct packed {
    logic       start_image;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        image_done;
  } out_word_t;

  // settings seen by the datapath
  typedef struct packed {
    logic [2:0]  pix_bytes;
    logic        rle_mode;
    logic        swap_red_blue;
    logic        clamp_index;
    logic [15:0] map_length;
    logic [31:0] pixel_total;
  } cfg_t;

  // status from the decode core to the handshake logic
  typedef struct packed {
    logic has_result;
    logic finished;
  } step_stat_t;

endpackage

>>> hdl/tgarle_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_cfg
// configuration registers and the registered pixel count of the image
// ----------------------------------------------------------------------------
module tgarle_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tgarle_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tgarle_pkg::CfgDataW-1:0]     cfg_data_i,
  output tgarle_pkg::cfg_t                    cfg_o
);

  logic [2:0]  bpp_q, bpp_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        rle_q, rle_d;
  logic        swap_q, swap_d;
  logic        clamp_q, clamp_d;
  logic [15:0] maplen_q, maplen_d;
  logic [31:0] total_q, total_d;

  always_comb begin
    bpp_d    = bpp_q;
    width_d  = width_q;
    height_d = height_q;
    rle_d    = rle_q;
    swap_d   = swap_q;
    clamp_d  = clamp_q;
    maplen_d = maplen_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tgarle_pkg::RegBytesPerPixel: bpp_d    = cfg_data_i[2:0];
        tgarle_pkg::RegImageWidth:    width_d  = cfg_data_i;
        tgarle_pkg::RegImageHeight:   height_d = cfg_data_i;
        tgarle_pkg::RegRleMode:       rle_d    = cfg_data_i[0];
        tgarle_pkg::RegSwapRedBlue:   swap_d   = cfg_data_i[0];
        tgarle_pkg::RegClampIndex:    clamp_d  = cfg_data_i[0];
        tgarle_pkg::RegMapLength:     maplen_d = cfg_data_i;
        default: ;
      endcase
    end
    // product follows the new width and height at the same edge
    total_d = 32'(width_d) * 32'(height_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= 3'd4;
      width_q  <= 16'd1;
      height_q <= 16'd1;
      rle_q    <= 1'b0;
      swap_q   <= 1'b0;
      clamp_q  <= 1'b0;
      maplen_q <= 16'd0;
      total_q  <= 32'd1;
    end else begin
      bpp_q    <= bpp_d;
      width_q  <= width_d;
      height_q <= height_d;
      rle_q    <= rle_d;
      swap_q   <= swap_d;
      clamp_q  <= clamp_d;
      maplen_q <= maplen_d;
      total_q  <= total_d;
    end
  end

  assign cfg_o.pix_bytes       = bpp_q;
  assign cfg_o.rle_mode        = rle_q;
  assign cfg_o.swap_red_blue   = swap_q;
  assign cfg_o.clamp_index     = clamp_q;
  assign cfg_o.map_length      = maplen_q;
  assign cfg_o.pixel_total     = total_q;

endmodule

>>> hdl/tgarle_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_xform
// red/blue exchange for true colour, index clamp for colour-mapped pixels
// ----------------------------------------------------------------------------
module tgarle_xform (
  input  logic [31:0] pixel_i,
  input  logic [2:0]  bpp_i,
  input  logic        swap_i,
  input  logic        clamp_i,
  input  logic [15:0] map_length_i,
  output logic [31:0] pixel_o
);

  always_comb begin
    pixel_o = pixel_i;
    if (swap_i) begin
      if (bpp_i >= 3'd3) begin
        pixel_o = {pixel_i[31:24], pixel_i[7:0], pixel_i[15:8], pixel_i[23:16]};
      end
    end else if (clamp_i) begin
      for (int k = 0; k < 4; k++) begin
        if ((3'(k) < bpp_i) && ({8'd0, pixel_i[8*k +: 8]} >= map_length_i)) begin
          pixel_o[8*k +: 8] = 8'd0;
        end
      end
    end
  end

endmodule

>>> hdl/tgarle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgarle_core
// packet, pixel and image state with the single-pass byte decode
// ----------------------------------------------------------------------------
module tgarle_core #(
  parameter int MaxPixelBytes = tgarle_pkg::MaxPixelBytesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  tgarle_pkg::in_word_t    word_i,
  input  tgarle_pkg::cfg_t        cfg_i,
  output tgarle_pkg::step_stat_t  stat_o,
  output tgarle_pkg::out_word_t   result_o
);

  localparam int GatherW = 8 * MaxPixelBytes;
  localparam logic [2:0] MaxBpp = 3'(MaxPixelBytes);

  logic               hdr_q, hdr_d;
  logic               is_run_q, is_run_d;
  logic [7:0]         pkt_left_q, pkt_left_d;
  logic [1:0]         pos_q, pos_d;
  logic [GatherW-1:0] gather_q, gather_d;
  logic [31:0]        img_left_q, img_left_d;
  logic               fin_q, fin_d;

  // state after an optional restart
  logic               hdr_c, is_run_c, fin_c;
  logic [7:0]         pkt_left_c;
  logic [1:0]         pos_c;
  logic [GatherW-1:0] gather_c, gather_new;
  logic [31:0]        img_left_c;

  logic [2:0]  bpp;
  logic [2:0]  pos_next;
  logic [7:0]  run;
  logic [31:0] run_cut;
  logic [31:0] left_after;
  logic [31:0] pixel_xf;
  logic        has_res;

  always_comb begin
    if (cfg_i.pix_bytes == 3'd0) begin
      bpp = 3'd1;
    end else if (cfg_i.pix_bytes > MaxBpp) begin
      bpp = MaxBpp;
    end else begin
      bpp = cfg_i.pix_bytes;
    end
  end

  always_comb begin
    if (word_i.start_image) begin
      hdr_c      = 1'b1;
      is_run_c   = 1'b0;
      pkt_left_c = 8'd0;
      pos_c      = 2'd0;
      gather_c   = '0;
      img_left_c = cfg_i.pixel_total;
      fin_c      = (cfg_i.pixel_total == 32'd0);
    end else begin
      hdr_c      = hdr_q;
      is_run_c   = is_run_q;
      pkt_left_c = pkt_left_q;
      pos_c      = pos_q;
      gather_c   = gather_q;
      img_left_c = img_left_q;
      fin_c      = fin_q;
    end
  end

  always_comb begin
    gather_new = gather_c;
    for (int k = 0; k < MaxPixelBytes; k++) begin
      if (pos_c == 2'(k)) begin
        gather_new[8*k +: 8] = gather_c[8*k +: 8] | word_i.data_byte;
      end
    end
  end

  assign pos_next = {1'b0, pos_c} + 3'd1;

  tgarle_xform u_xform (
    .pixel_i      (32'(gather_new)),
    .bpp_i        (bpp),
    .swap_i       (cfg_i.swap_red_blue),
    .clamp_i      (cfg_i.clamp_index),
    .map_length_i (cfg_i.map_length),
    .pixel_o      (pixel_xf)
  );

  always_comb begin
    hdr_d      = hdr_c;
    is_run_d   = is_run_c;
    pkt_left_d = pkt_left_c;
    pos_d      = pos_c;
    gather_d   = gather_c;
    img_left_d = img_left_c;
    fin_d      = fin_c;
    has_res    = 1'b0;
    run        = 8'd1;
    run_cut    = 32'd0;
    left_after = img_left_c;

    if (fin_c) begin
      // surplus byte, dropped
    end else if (cfg_i.rle_mode && hdr_c) begin
      is_run_d   = word_i.data_byte[tgarle_pkg::HdrRunBit];
      pkt_left_d = {1'b0, word_i.data_byte[6:0] & tgarle_pkg::HdrCountMask} + 8'd1;
      hdr_d      = 1'b0;
      pos_d      = 2'd0;
      gather_d   = '0;
    end else if (pos_next < bpp) begin
      pos_d    = pos_next[1:0];
      gather_d = gather_new;
    end else begin
      has_res  = 1'b1;
      pos_d    = 2'd0;
      gather_d = '0;
      if (cfg_i.rle_mode && is_run_c) begin
        run        = (pkt_left_c == 8'd0) ? 8'd1 : pkt_left_c;
        pkt_left_d = 8'd0;
        hdr_d      = 1'b1;
      end else if (cfg_i.rle_mode) begin
        if (pkt_left_c > 8'd1) begin
          pkt_left_d = pkt_left_c - 8'd1;
        end else begin
          pkt_left_d = 8'd0;
          hdr_d      = 1'b1;
        end
      end
      // cut the run to what is left of the image
      run_cut    = (32'(run) > img_left_c) ? img_left_c : 32'(run);
      left_after = img_left_c - run_cut;
      img_left_d = left_after;
      fin_d      = (left_after == 32'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q      <= 1'b1;
      is_run_q   <= 1'b0;
      pkt_left_q <= 8'd0;
      pos_q      <= 2'd0;
      gather_q   <= '0;
      img_left_q <= 32'd1;
      fin_q      <= 1'b0;
    end else if (step_i) begin
      hdr_q      <= hdr_d;
      is_run_q   <= is_run_d;
      pkt_left_q <= pkt_left_d;
      pos_q      <= pos_d;
      gather_q   <= gather_d;
      img_left_q <= img_left_d;
      fin_q      <= fin_d;
    end
  end

  assign stat_o.has_result    = has_res;
  assign stat_o.finished      = fin_q;
  assign result_o.pixel_value = pixel_xf;
  assign result_o.run_length  = run_cut[7:0];
  assign result_o.image_done  = fin_d;

endmodule

>>> hdl/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// tga image payload decoder: bytes in, pixels with run lengths out
// ----------------------------------------------------------------------------
// Takes one payload byte per clock and sustains one byte per cycle under
// continuous flow. A byte is latched in an input register, decoded by one
// pass of counter and byte-lane logic, and any pixel it completes lands in
// the result register. Header bytes, partial pixel bytes and bytes past
// the end of the image produce no word on the output. The image pixel count
// is a 16x16 product taken in a register at the same edge as a width or
// height write, so a new image may start on the cycle after configuration.
// The input side keeps taking bytes while a result waits on the output,
// and stalls only when a pending byte would produce a second result that
// has nowhere to go.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int MaxPixelBytes = tgarle_pkg::MaxPixelBytesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // payload byte channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tgarle_pkg::in_word_t             in_word_i,
  // pixel channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tgarle_pkg::out_word_t            out_word_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tgarle_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgarle_pkg::CfgDataW-1:0]  cfg_data_i
);

  tgarle_pkg::cfg_t       cfg;
  tgarle_pkg::step_stat_t stat;
  tgarle_pkg::out_word_t  result;

  // input register
  logic                 s1_valid_q, s1_valid_d;
  tgarle_pkg::in_word_t s1_word_q;

  // result register
  logic                  out_valid_q, out_valid_d;
  tgarle_pkg::out_word_t out_word_q;

  logic in_take;
  logic out_free;
  logic step;
  logic load_out;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  tgarle_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tgarle_core #(
    .MaxPixelBytes (MaxPixelBytes)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (s1_word_q),
    .cfg_i    (cfg),
    .stat_o   (stat),
    .result_o (result)
  );

  // the held byte retires unless it makes a pixel and the result slot is busy
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && (!stat.has_result || out_free);
  assign load_out   = step && stat.has_result;
  assign in_ready_o = !s1_valid_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_word_q <= in_word_i;
    end
    if (load_out) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a decoded pixel always reaches the output on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("decoded pixel not presented");

  // a pending pixel with a stalled output must hold off new bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && stat.has_result && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("byte accepted over a blocked result");

  // without packets every pixel stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !cfg.rle_mode) |-> (result.run_length == 8'd1))
    else $error("run length above one outside rle mode");

  // a run is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (result.run_length != 8'd0))
    else $error("zero run length");

  // the last pixel of an image leaves the decoder in the finished state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && result.image_done) |=> stat.finished)
    else $error("image done without finished state");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the tga rle pixel decoder
// ----------------------------------------------------------------------------
// Drives payload bytes and register writes through the valid/ready ports and
// predicts every pixel word from an in-bench decoder with its own copy of the
// settings and packet state. A checker pops the oldest prediction for each
// accepted pixel word. Directed cases cover reset defaults, run and raw
// packets, run cutting, odd pixel sizes, swap and clamp, and empty images.
// Random images with random settings follow under three idle mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int MaxBytes = tgarle_pkg::MaxPixelBytesDefault;
  // index that maps to no register, writes to it must be ignored
  localparam logic [tgarle_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int RandomBytesPerMix = 360;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // byte side
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tgarle_pkg::in_word_t in_word = '0;

  // pixel side
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tgarle_pkg::out_word_t out_word;

  // register port
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tgarle_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [tgarle_pkg::CfgDataW-1:0] cfg_data = '0;

  tga_rle_pixel_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle percentages for the byte sender and the pixel receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // bookkeeping
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned restarts = 0;
  int unsigned mismatches = 0;

  // predicted pixel words, oldest first
  tgarle_pkg::out_word_t pixel_q[$];

  // in-bench copy of the register file
  logic [2:0]  set_bpp;
  logic [15:0] set_width;
  logic [15:0] set_height;
  logic        set_rle;
  logic        set_swap;
  logic        set_clamp;
  logic [15:0] set_map_len;

  // in-bench copy of the decode state
  logic        hdr_pending;
  logic        pkt_is_run;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_pos;
  logic [31:0] gather;
  logic [31:0] pix_left;
  logic        img_finished;

  // set on the next payload byte to open a new image
  logic start_next = 1'b0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // pixel count is taken from the settings as they stand on the start byte
  function automatic void restart_image();
    hdr_pending  = 1'b1;
    pkt_is_run   = 1'b0;
    pkt_left     = '0;
    byte_pos     = '0;
    gather       = '0;
    pix_left     = 32'(set_width) * 32'(set_height);
    img_finished = (pix_left == 0);
  endfunction

  function automatic void reset_decoder_copy();
    set_bpp     = 3'd4;
    set_width   = 16'd1;
    set_height  = 16'd1;
    set_rle     = 1'b0;
    set_swap    = 1'b0;
    set_clamp   = 1'b0;
    set_map_len = '0;
    restart_image();
  endfunction

  // bytes per pixel as the datapath sees it: 0 acts as 1, oversize is capped
  function automatic int unsigned pixel_bytes(logic [2:0] bpp);
    if (bpp == 0) return 1;
    if (bpp > MaxBytes) return MaxBytes;
    return bpp;
  endfunction

  // red/blue exchange wins over index clamping; swap needs three bytes
  function automatic logic [31:0] recolor(logic [31:0] px, int unsigned nbytes);
    logic [31:0] r;
    int unsigned k;
    r = px;
    if (set_swap) begin
      if (nbytes >= 3) r = {px[31:24], px[7:0], px[15:8], px[23:16]};
    end else if (set_clamp) begin
      for (k = 0; k < nbytes; k++) begin
        if ({8'h00, px[8*k +: 8]} >= set_map_len) r[8*k +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

  // advance the decode state by one accepted byte, queue any pixel word
  function automatic void decode_byte(tgarle_pkg::in_word_t w);
    int unsigned           nbytes;
    int unsigned           pos;
    int unsigned           run;
    tgarle_pkg::out_word_t px;
    if (w.start_image) restart_image();
    if (img_finished) return;
    nbytes = pixel_bytes(set_bpp);
    // packet header: run flag and pixel count minus one
    if (set_rle && hdr_pending) begin
      pkt_is_run  = w.data_byte[tgarle_pkg::HdrRunBit];
      pkt_left    = {1'b0, w.data_byte[6:0]} + 8'd1;
      hdr_pending = 1'b0;
      byte_pos    = '0;
      gather      = '0;
      return;
    end
    pos    = byte_pos;
    gather = gather | (32'(w.data_byte) << (8 * pos));
    pos++;
    if (pos < nbytes) begin
      byte_pos = 2'(pos);
      return;
    end
    px.pixel_value = recolor(gather, nbytes);
    byte_pos = '0;
    gather   = '0;
    if (set_rle && pkt_is_run) begin
      run = pkt_left;
      if (run == 0) run = 1;
      pkt_left    = '0;
      hdr_pending = 1'b1;
    end else begin
      run = 1;
      if (set_rle) begin
        if (pkt_left > 0) pkt_left--;
        if (pkt_left == 0) hdr_pending = 1'b1;
      end
    end
    // runs never reach past the end of the image
    if (run > pix_left) run = pix_left;
    pix_left -= run;
    if (pix_left == 0) img_finished = 1'b1;
    px.run_length = run[7:0];
    px.image_done = img_finished;
    pixel_q.insert(pixel_q.size(), px);
  endfunction

  // --------------------------------------------------------------------------
  // pixel checker: compare every accepted word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    tgarle_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel word: value %h run %0d done %b",
                   out_word.pixel_value, out_word.run_length, out_word.image_done);
      end else begin
        want = pixel_q.pop_front();
        words_checked++;
        if (out_word.pixel_value !== want.pixel_value ||
            out_word.run_length !== want.run_length ||
            out_word.image_done !== want.image_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected value %h run %0d done %b, got value %h run %0d done %b",
                     words_checked, want.pixel_value, want.run_length, want.image_done,
                     out_word.pixel_value, out_word.run_length, out_word.image_done);
        end
      end
    end
  end

  // receiver back-pressure, one decision per cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // one payload byte: optional idle gap, then hold until taken
  task automatic send_byte(tgarle_pkg::in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (w.start_image) restarts++;
    decode_byte(w);
  endtask

  // payload byte that opens an image when start_next is set; rare stray
  // start bits break the sequence on purpose
  task automatic send_data(logic [7:0] b);
    tgarle_pkg::in_word_t w;
    w.data_byte   = b;
    w.start_image = start_next | ($urandom_range(79) == 0);
    start_next    = 1'b0;
    send_byte(w);
  endtask

  // stop sending and let everything predicted come out, then keep idle
  // for any byte still in flight that makes no word
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(logic [tgarle_pkg::CfgIdxW-1:0] idx,
                           logic [tgarle_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      tgarle_pkg::RegBytesPerPixel: set_bpp     = data[2:0];
      tgarle_pkg::RegImageWidth:    set_width   = data;
      tgarle_pkg::RegImageHeight:   set_height  = data;
      tgarle_pkg::RegRleMode:       set_rle     = data[0];
      tgarle_pkg::RegSwapRedBlue:   set_swap    = data[0];
      tgarle_pkg::RegClampIndex:    set_clamp   = data[0];
      tgarle_pkg::RegMapLength:     set_map_len = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full register set; narrow registers get junk in their unused bits
  task automatic set_image_regs(logic [2:0] bpp, logic [15:0] w, logic [15:0] h,
                                logic rle, logic swap, logic clamp, logic [15:0] mlen);
    wait_idle();
    write_reg(tgarle_pkg::RegBytesPerPixel, {13'($urandom), bpp});
    write_reg(tgarle_pkg::RegImageWidth, w);
    write_reg(tgarle_pkg::RegImageHeight, h);
    write_reg(tgarle_pkg::RegRleMode, {15'($urandom), rle});
    write_reg(tgarle_pkg::RegSwapRedBlue, {15'($urandom), swap});
    write_reg(tgarle_pkg::RegClampIndex, {15'($urandom), clamp});
    write_reg(tgarle_pkg::RegMapLength, mlen);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // defaults after reset: 4-byte pixel, 1x1 image, no start byte needed
  task automatic test_reset_state();
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hFF);
    // image is done, this one is surplus
    send_data(8'hA5);
  endtask

  // run packet cut to the image, raw packet, one-pixel run, swap over clamp
  task automatic test_packet_kinds();
    set_image_regs(3'd3, 16'd2, 16'd1, 1'b1, 1'b1, 1'b1, 16'd0);
    start_next = 1'b1;
    send_data(8'hFF);             // run of 128, only 2 pixels remain
    send_data(8'h11);
    send_data(8'h22);
    send_data(8'h33);
    send_data(8'h5A);             // dropped after the end
    start_next = 1'b1;
    send_data(8'h00);             // raw packet of one pixel
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(8'h80);             // run of one closes the image
    send_data(8'h01);
    send_data(8'h02);
    send_data(8'h03);
  endtask

  // zero pixel size, largest image, swap on short pixels, mode change mid-image
  task automatic test_pixel_sizes();
    set_image_regs(3'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'hFFFF);
    write_reg(RegUnused, 16'hFFFF);
    start_next = 1'b1;
    send_data(8'h7F);             // raw packet of 128
    send_data(8'h80);
    send_data(8'h01);
    // uncompressed from here on, packet state left alone
    wait_idle();
    write_reg(tgarle_pkg::RegRleMode, 16'd0);
    send_data(8'hFE);
    send_data(8'h7F);
  endtask

  // oversize pixel size, empty image, clamp at the top of the byte range
  task automatic test_clamp_and_empty();
    set_image_regs(3'd7, 16'd1, 16'd0, 1'b0, 1'b0, 1'b1, 16'd255);
    start_next = 1'b1;
    send_data(8'hFF);             // empty image drops everything
    send_data(8'h00);
    wait_idle();
    write_reg(tgarle_pkg::RegImageHeight, 16'd3);
    start_next = 1'b1;
    send_data(8'hFF);
    send_data(8'hFE);
    send_data(8'h00);
    send_data(8'h7F);
  endtask

  // one random image: mostly well-formed packets, some truncation and surplus
  task automatic send_image(int unsigned nbytes, logic rle, int unsigned total);
    int unsigned target;
    int unsigned covered;
    int unsigned cnt;
    int unsigned rem;
    logic        is_run;
    target = (total > 40) ? 40 : total;
    if (target > 1 && $urandom_range(7) == 0) target--;
    start_next = ($urandom_range(9) != 0);
    covered = 0;
    if (target == 0) repeat ($urandom_range(1, 3)) send_data(8'($urandom));
    while (covered < target) begin
      if (rle) begin
        is_run = 1'($urandom_range(1));
        rem = target - covered;
        if (is_run)
          cnt = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(5);
        else
          cnt = $urandom_range((rem > 8) ? 7 : rem);
        send_data({is_run, cnt[6:0]});
        repeat (is_run ? 1 : cnt + 1) begin
          repeat (nbytes) send_data(8'($urandom));
        end
        covered += cnt + 1;
      end else begin
        repeat (nbytes) send_data(8'($urandom));
        covered++;
      end
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_data(8'($urandom));
  endtask

  task automatic test_random_stream(int unsigned n_bytes);
    int unsigned stop_at;
    logic [2:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] mlen;
    logic        rle;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      bpp = ($urandom_range(9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
      case ($urandom_range(19))
        0: begin w = 16'hFFFF; h = 16'($urandom_range(1, 2)); end
        1: begin
          w = 16'($urandom_range(1));
          h = (w == 0) ? 16'($urandom_range(3)) : 16'd0;
        end
        2: begin w = 16'($urandom_range(1, 3)); h = 16'hFFFF; end
        default: begin w = 16'($urandom_range(1, 8)); h = 16'($urandom_range(1, 4)); end
      endcase
      case ($urandom_range(3))
        0: mlen = 16'd0;
        1: mlen = 16'($urandom_range(1, 256));
        2: mlen = 16'hFFFF;
        default: mlen = 16'($urandom);
      endcase
      rle = ($urandom_range(9) < 7);
      set_image_regs(bpp, w, h, rle, 1'($urandom_range(1)), 1'($urandom_range(1)), mlen);
      send_image(pixel_bytes(bpp), rle, 32'(w) * 32'(h));
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_decoder_copy();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 21;
    recv_idle_pct = 78;
    test_reset_state();
    test_packet_kinds();
    test_pixel_sizes();
    test_clamp_and_empty();
    test_random_stream(RandomBytesPerMix);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 78;
    recv_idle_pct = 21;
    test_random_stream(RandomBytesPerMix);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(RandomBytesPerMix);

    wait_idle();
    $display("sent %0d payload bytes with %0d image starts, checked %0d pixel words",
             bytes_sent, restarts, words_checked);
    $display("%0d register writes, %0d mismatches, three idle mixes", reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tga_rle_pixel_decoder test passed");
    end else begin
      $display("tga_rle_pixel_decoder test failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #(4_000_000);
    $display("tga_rle_pixel_decoder test failed");
    $finish;
  end

endmodule
